/* hdl/icc_pkg.sv */
package icc_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [6:0] OVL_LIMIT_MAX   = 7'd75;
    localparam logic [6:0] OVL_LIMIT_RST   = 7'd60;
    localparam logic [7:0] AC_LOW_MAX_RST  = 8'd82;
    localparam logic [7:0] AC_HIGH_MIN_RST = 8'd123;
    localparam logic [7:0] CHG_SPLIT_RST   = 8'd102;
    localparam logic [7:0] BATT_LOW_RST    = 8'd54;
    localparam logic [7:0] BATT_FULL_RST   = 8'd73;

    // load percent = floor(load * LOAD_PCT_MUL / LOAD_PCT_DIV)
    localparam logic [4:0]  LOAD_PCT_MUL = 5'd20;
    localparam logic [5:0]  LOAD_PCT_DIV = 6'd51;

    localparam logic [2:0] MAINS_CNT_MAX   = 3'd5;
    localparam logic [3:0] CHARGE_CNT_MAX  = 4'd8;
    localparam logic [3:0] MODE_CNT_MAX    = 4'd10;
    localparam logic [3:0] MODE_CNT_RESUME = 4'd5;
    localparam logic [2:0] OVL_CNT_MAX     = 3'd5;
    localparam logic [2:0] LOWBATT_CNT_MAX = 3'd5;
    localparam logic [2:0] LOAD_DLY_MAX    = 3'd6;
    localparam logic [2:0] LOAD_DLY_ARM    = 3'd5;
    localparam logic [2:0] CNT3_INIT       = 3'd1;
    localparam logic [3:0] CNT4_INIT       = 4'd1;

    localparam logic [1:0] REM_OFF = 2'd0;
    localparam logic [1:0] REM_ON  = 2'd1;

    typedef enum logic [1:0] {
        EV_CLEAR      = 2'd0,
        EV_BATT_LOW   = 2'd1,
        EV_MAINS      = 2'd2,
        EV_CHARGE_REQ = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        REG_OVL_LIMIT   = 3'd0,
        REG_CHG_UPGRADE = 3'd1,
        REG_AC_LOW_MAX  = 3'd2,
        REG_AC_HIGH_MIN = 3'd3,
        REG_CHG_SPLIT   = 3'd4,
        REG_BATT_LOW    = 3'd5,
        REG_BATT_FULL   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [6:0] overload_limit;
        logic       charge_upgrade;
        logic [7:0] ac_low_max;
        logic [7:0] ac_high_min;
        logic [7:0] charge_split;
        logic [7:0] batt_low_below;
        logic [7:0] batt_full_above;
    } t_cfg;

    typedef struct packed {
        logic       func;
        logic [7:0] ac_sample;
        logic [7:0] batt_sample;
        logic [7:0] load_sample;
        logic [1:0] remote_cmd;
    } t_item;

    typedef struct packed {
        logic       on_mains;
        logic       low_batt;
        logic       overload;
        logic       full;
        logic       charging;
        logic       mode_set;
        logic       power;
        logic       load;
        logic       pin_relay;
        logic       pin_chg;
        logic       pin_sel;
        logic [2:0] mains_count;
        logic [3:0] charge_count;
        logic [3:0] mode_count;
        logic [2:0] overload_count;
        logic [2:0] lowbatt_count;
        logic [2:0] load_dly_count;
        t_event     event_now;
        t_event     event_saved;
    } t_state;

    typedef struct packed {
        logic       mains_selected;
        logic       charge_on;
        logic       chg_rate_sel;
        logic       inverter_on;
        logic       load_on;
        t_event     display_event;
        logic       low_battery;
        logic       overloaded;
        logic       fully_charged;
    } t_result;

endpackage

/* hdl/icc_cfg.sv */
module icc_cfg
    import icc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output t_cfg                o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       w_wr;
    t_reg_idx   w_idx;
    logic [6:0] w_lim;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_lim  = (pwdata[6:0] > OVL_LIMIT_MAX) ? OVL_LIMIT_MAX : pwdata[6:0];

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_OVL_LIMIT:   n_cfg.overload_limit  = w_lim;
                REG_CHG_UPGRADE: n_cfg.charge_upgrade  = pwdata[0];
                REG_AC_LOW_MAX:  n_cfg.ac_low_max      = pwdata[7:0];
                REG_AC_HIGH_MIN: n_cfg.ac_high_min     = pwdata[7:0];
                REG_CHG_SPLIT:   n_cfg.charge_split    = pwdata[7:0];
                REG_BATT_LOW:    n_cfg.batt_low_below  = pwdata[7:0];
                REG_BATT_FULL:   n_cfg.batt_full_above = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.overload_limit  <= OVL_LIMIT_RST;
            r_cfg.charge_upgrade  <= 1'b0;
            r_cfg.ac_low_max      <= AC_LOW_MAX_RST;
            r_cfg.ac_high_min     <= AC_HIGH_MIN_RST;
            r_cfg.charge_split    <= CHG_SPLIT_RST;
            r_cfg.batt_low_below  <= BATT_LOW_RST;
            r_cfg.batt_full_above <= BATT_FULL_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_OVL_LIMIT:   prdata = DATA_W'(r_cfg.overload_limit);
            REG_CHG_UPGRADE: prdata = DATA_W'(r_cfg.charge_upgrade);
            REG_AC_LOW_MAX:  prdata = DATA_W'(r_cfg.ac_low_max);
            REG_AC_HIGH_MIN: prdata = DATA_W'(r_cfg.ac_high_min);
            REG_CHG_SPLIT:   prdata = DATA_W'(r_cfg.charge_split);
            REG_BATT_LOW:    prdata = DATA_W'(r_cfg.batt_low_below);
            REG_BATT_FULL:   prdata = DATA_W'(r_cfg.batt_full_above);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/icc_step.sv */
module icc_step
    import icc_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    input  t_state  i_state,
    output t_state  o_state
);

    function automatic t_state ev_save(input t_state st, input t_event e);
        t_state r;
        r = st;
        if (e != st.event_now) begin
            r.event_saved = st.event_now;
            r.event_now   = e;
        end
        return r;
    endfunction

    function automatic t_state power_off(input t_state st);
        t_state r;
        r = st;
        if (st.low_batt) begin
            r = ev_save(st, EV_CHARGE_REQ);
        end else if (st.event_now == EV_CHARGE_REQ) begin
            r.event_now = st.event_saved;
        end
        r.power = 1'b0;
        return r;
    endfunction

    t_state      s;
    logic [12:0] w_load_x20;
    logic [12:0] w_lim_x51;
    logic        w_ovl_hit;
    logic        w_ac_bad;
    logic        w_upgrade;

    // pct > limit  <=>  load*20 >= (limit+1)*51
    assign w_load_x20 = 13'(i_item.load_sample) * 13'(LOAD_PCT_MUL);
    assign w_lim_x51  = (13'(i_cfg.overload_limit) + 13'd1) * 13'(LOAD_PCT_DIV);
    assign w_ovl_hit  = (w_load_x20 >= w_lim_x51);
    assign w_ac_bad   = (i_item.ac_sample <= i_cfg.ac_low_max) ||
                        (i_item.ac_sample >= i_cfg.ac_high_min);
    assign w_upgrade  = (i_item.ac_sample < i_cfg.charge_split) ?
                        i_cfg.charge_upgrade : !i_cfg.charge_upgrade;

    always_comb begin
        s = i_state;
        if (i_item.func) begin
            if (i_state.mains_count < MAINS_CNT_MAX && !i_state.on_mains)
                s.mains_count = i_state.mains_count + 3'd1;
            if (i_state.charge_count < CHARGE_CNT_MAX && !i_state.charging)
                s.charge_count = i_state.charge_count + 4'd1;
            if (i_state.mode_count < MODE_CNT_MAX && !i_state.mode_set)
                s.mode_count = i_state.mode_count + 4'd1;
            if (i_state.overload_count < OVL_CNT_MAX && i_state.overload)
                s.overload_count = i_state.overload_count + 3'd1;
            if (i_state.lowbatt_count < LOWBATT_CNT_MAX && i_state.low_batt)
                s.lowbatt_count = i_state.lowbatt_count + 3'd1;
            if (!i_state.on_mains && i_state.power && i_state.load_dly_count < LOAD_DLY_MAX)
                s.load_dly_count = i_state.load_dly_count + 3'd1;
        end else if (w_ac_bad) begin
            s.on_mains  = 1'b0;
            s.full      = 1'b0;
            s.pin_relay = 1'b0;
            s.pin_chg   = 1'b0;
            s.charging  = 1'b0;
            if (i_item.remote_cmd == REM_ON) begin
                if (s.low_batt) begin
                    s = power_off(s);
                end else if (i_item.batt_sample < i_cfg.batt_low_below) begin
                    s.low_batt = 1'b1;
                    if (s.lowbatt_count == LOWBATT_CNT_MAX)
                        s = power_off(s);
                end else begin
                    s.lowbatt_count = CNT3_INIT;
                    s.low_batt      = 1'b0;
                    if (s.load_dly_count == LOAD_DLY_MAX)
                        s.load_dly_count = CNT3_INIT;
                    s.power = 1'b1;
                end
            end else if (i_item.remote_cmd == REM_OFF) begin
                s.load_dly_count = CNT3_INIT;
                s.load           = 1'b0;
                s = power_off(s);
            end
            if (w_ovl_hit) begin
                s.overload = 1'b1;
                if (s.overload_count == OVL_CNT_MAX) begin
                    s.load_dly_count = CNT3_INIT;
                    s.load           = 1'b0;
                end
            end else begin
                s.overload       = 1'b0;
                s.overload_count = CNT3_INIT;
                if (s.load_dly_count == LOAD_DLY_ARM)
                    s.load = 1'b1;
            end
            s.mains_count  = CNT3_INIT;
            s.charge_count = CNT4_INIT;
            s.mode_count   = CNT4_INIT;
        end else begin
            s = ev_save(s, EV_MAINS);
            if (s.mains_count == MAINS_CNT_MAX) begin
                s.on_mains  = 1'b1;
                s.low_batt  = 1'b0;
                s = power_off(s);
                s.pin_relay = 1'b1;
                if (s.charge_count == CHARGE_CNT_MAX) begin
                    if (i_item.batt_sample > i_cfg.batt_full_above) begin
                        s.full    = 1'b1;
                        s.pin_chg = 1'b0;
                    end else begin
                        if (!s.full)
                            s.pin_chg = 1'b1;
                        if (s.mode_set && s.mode_count == MODE_CNT_MAX) begin
                            s.mode_count = MODE_CNT_RESUME;
                            s.mode_set   = 1'b0;
                        end
                        if (s.mode_count == MODE_CNT_MAX) begin
                            s.pin_sel  = !w_upgrade;
                            s.mode_set = 1'b1;
                        end
                    end
                    s.charging = 1'b1;
                end
                s.load_dly_count = LOAD_DLY_ARM;
                s.load           = 1'b1;
                s.overload_count = CNT3_INIT;
            end
        end
    end

    assign o_state = s;

endmodule

/* hdl/inverter_changeover_controller.sv */
// Mains/inverter change-over controller.
// Input channel: i_valid / o_stall carry one request per cycle unless stalled.
// func = 1 is a one-second tick advancing the debounce counters; func = 0 is a
// monitor pass with latest AC, battery and load samples and the remote command.
// Output channel: o_valid / i_stall. Every request yields exactly one result
// showing relay, charger, charge-rate, inverter and load outputs, the display
// event and the status flags after that request.
// A request passes through the input register, then the decision logic into
// the result register. Throughput: one request per cycle while the receiver
// does not stall; the controller state is updated as a request moves into the
// result register, so consecutive requests see each other's effect.
// When the receiver stalls, the result register holds and the input register
// can still take one more request; o_stall rises only when both are full.
// Thresholds live in an APB register file (byte address 4*index); write them
// only while no request is in flight.
// Reset (synchronous, active low) clears both channel registers, loads the
// register defaults and puts the controller on the inverter side with all
// outputs off, counters at 1 and the display on mains info.
module inverter_changeover_controller
    import icc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_func,
    input  logic [7:0]          i_ac_sample,
    input  logic [7:0]          i_batt_sample,
    input  logic [7:0]          i_load_sample,
    input  logic [1:0]          i_remote_cmd,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_mains_selected,
    output logic                o_charge_on,
    output logic                o_chg_rate_sel,
    output logic                o_inverter_on,
    output logic                o_load_on,
    output logic [1:0]          o_display_event,
    output logic                o_low_battery,
    output logic                o_overloaded,
    output logic                o_fully_charged
);

    t_cfg    w_cfg;
    t_item   r_in;
    logic    r_in_vld;
    logic    r_out_vld;
    t_result r_out;
    t_state  r_state;
    t_state  n_state;
    t_result n_out;
    logic    w_adv;
    logic    w_acc;

    icc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    icc_step u_step (
        .i_cfg   (w_cfg),
        .i_item  (r_in),
        .i_state (r_state),
        .o_state (n_state)
    );

    assign w_adv   = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !w_adv;
    assign w_acc   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_in.func        <= i_func;
            r_in.ac_sample   <= i_ac_sample;
            r_in.batt_sample <= i_batt_sample;
            r_in.load_sample <= i_load_sample;
            r_in.remote_cmd  <= i_remote_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_comb begin
        n_out.mains_selected = n_state.pin_relay;
        n_out.charge_on      = n_state.pin_chg;
        n_out.chg_rate_sel   = n_state.pin_sel;
        n_out.inverter_on    = n_state.power;
        n_out.load_on        = n_state.load;
        n_out.display_event  = n_state.event_now;
        n_out.low_battery    = n_state.low_batt;
        n_out.overloaded     = n_state.overload;
        n_out.fully_charged  = n_state.full;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.on_mains       <= 1'b0;
            r_state.low_batt       <= 1'b0;
            r_state.overload       <= 1'b0;
            r_state.full           <= 1'b0;
            r_state.charging       <= 1'b0;
            r_state.mode_set       <= 1'b0;
            r_state.power          <= 1'b0;
            r_state.load           <= 1'b0;
            r_state.pin_relay      <= 1'b0;
            r_state.pin_chg        <= 1'b0;
            r_state.pin_sel        <= 1'b0;
            r_state.mains_count    <= CNT3_INIT;
            r_state.charge_count   <= CNT4_INIT;
            r_state.mode_count     <= CNT4_INIT;
            r_state.overload_count <= CNT3_INIT;
            r_state.lowbatt_count  <= CNT3_INIT;
            r_state.load_dly_count <= CNT3_INIT;
            r_state.event_now      <= EV_MAINS;
            r_state.event_saved    <= EV_MAINS;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_mains_selected = r_out.mains_selected;
    assign o_charge_on      = r_out.charge_on;
    assign o_chg_rate_sel   = r_out.chg_rate_sel;
    assign o_inverter_on    = r_out.inverter_on;
    assign o_load_on        = r_out.load_on;
    assign o_display_event  = r_out.display_event;
    assign o_low_battery    = r_out.low_battery;
    assign o_overloaded     = r_out.overloaded;
    assign o_fully_charged  = r_out.fully_charged;

    a_relay_tracks_mains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pin_relay == r_state.on_mains)
        else $error("relay pin differs from mains state");

    a_no_inverter_on_mains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.on_mains |-> !r_state.power)
        else $error("inverter powered while on mains");

    a_charger_needs_mains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pin_chg |-> r_state.on_mains)
        else $error("charger enabled off mains");

    a_counters_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mains_count <= MAINS_CNT_MAX && r_state.charge_count <= CHARGE_CNT_MAX &&
        r_state.mode_count <= MODE_CNT_MAX && r_state.load_dly_count <= LOAD_DLY_MAX &&
        r_state.overload_count <= OVL_CNT_MAX && r_state.lowbatt_count <= LOWBATT_CNT_MAX)
        else $error("debounce counter past its limit");

    a_held_request_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> r_in_vld)
        else $error("pending request dropped");

endmodule
